[sv/afi_pkg.sv]
// Shared types, constants and fixed-point helpers for the acoustic face flux block.
package afi_pkg;

  localparam int unsigned NORM_FRAC = 14;
  localparam int unsigned R_FRAC    = 30;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DIV_STEPS = R_FRAC + 1;
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QPTR_W    = $clog2(QDEPTH);
  localparam int unsigned NSTAGE_B  = 13;

  typedef enum logic [1:0] {
    CFG_INV_DENSITY    = 2'd0,
    CFG_SOUND_SPEED_SQ = 2'd1,
    CFG_CHAR_IMPEDANCE = 2'd2
  } cfg_idx_e;

  typedef logic signed [65:0] wide_t;

  typedef struct packed {
    logic signed [31:0] p_in;
    logic signed [31:0] ux_in;
    logic signed [31:0] uy_in;
    logic signed [31:0] p_out;
    logic signed [31:0] ux_out;
    logic signed [31:0] uy_out;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic               wall;
    logic [31:0]        zw;
  } item_t;

  typedef struct packed {
    item_t              it;
    logic signed [31:0] refl;
  } qent_t;

  // Right shift rounding to nearest, ties away from zero.
  function automatic wide_t rnd_shr(wide_t x, int unsigned s);
    wide_t half;
    wide_t neg;
    half = wide_t'(1) <<< (s - 1);
    neg  = x[65] ? wide_t'(1) : wide_t'(0);
    return (x + half - neg) >>> s;
  endfunction

  function automatic logic signed [31:0] sat32(wide_t x);
    wide_t hi;
    wide_t lo;
    hi = wide_t'(64'sh0000_0000_7FFF_FFFF);
    lo = -wide_t'(64'sh0000_0000_8000_0000);
    if (x > hi) begin
      return hi[31:0];
    end else if (x < lo) begin
      return lo[31:0];
    end
    return x[31:0];
  endfunction

  function automatic logic signed [48:0] clamp48(wide_t x);
    wide_t lim;
    lim = wide_t'(1) <<< 47;
    if (x > lim) begin
      return lim[48:0];
    end else if (x < -lim) begin
      return 49'(-lim);
    end
    return x[48:0];
  endfunction

endpackage

[sv/afi_front.sv]
// Front end: accepts face nodes and computes the wall reflection coefficient.
module afi_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  afi_pkg::item_t      in_item_i,
  input  logic [31:0]         char_impedance_i,
  output logic                push_o,
  input  logic                push_ready_i,
  output afi_pkg::qent_t      push_ent_o
);

  localparam int unsigned N = afi_pkg::DIV_STEPS;

  logic                   fv_q  [0:N];
  logic [32:0]            rem_q [0:N];
  logic [N-1:0]           nlo_q [0:N];
  logic [N-1:0]           quo_q [0:N];
  logic [32:0]            den_q [0:N];
  logic                   neg_q [0:N];
  logic                   rig_q [0:N];
  afi_pkg::item_t         it_q  [0:N];

  logic [32:0]            rem_d [1:N];
  logic [N-1:0]           quo_d [1:N];
  logic                   en;

  logic [32:0]            den0;
  logic                   neg0;
  logic [31:0]            mag0;
  logic [62:0]            num0;

  assign en         = !(fv_q[N] && !push_ready_i);
  assign in_ready_o = en;
  assign push_o     = fv_q[N] && push_ready_i;

  always_comb begin
    den0 = {1'b0, in_item_i.zw} + {1'b0, char_impedance_i};
    neg0 = in_item_i.zw < char_impedance_i;
    mag0 = neg0 ? (char_impedance_i - in_item_i.zw) : (in_item_i.zw - char_impedance_i);
    // Numerator of the rounded quotient: |Zw-Z| * 2^30 + floor(den/2).
    num0 = 63'({mag0, 30'b0}) + 63'(den0[32:1]);
  end

  // One restoring division step per stage.
  always_comb begin
    logic [33:0] t;
    logic        ge;
    for (int j = 1; j <= N; j++) begin
      t        = {rem_q[j-1], nlo_q[j-1][N-j]};
      ge       = t >= {1'b0, den_q[j-1]};
      rem_d[j] = ge ? 33'(t - {1'b0, den_q[j-1]}) : t[32:0];
      quo_d[j] = {quo_q[j-1][N-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j <= N; j++) begin
        fv_q[j] <= 1'b0;
      end
    end else if (en) begin
      fv_q[0] <= in_valid_i;
      for (int j = 1; j <= N; j++) begin
        fv_q[j] <= fv_q[j-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rem_q[0] <= {1'b0, num0[62:31]};
      nlo_q[0] <= num0[N-1:0];
      quo_q[0] <= '0;
      den_q[0] <= den0;
      neg_q[0] <= neg0;
      rig_q[0] <= (in_item_i.zw == 32'd0);
      it_q[0]  <= in_item_i;
      for (int j = 1; j <= N; j++) begin
        rem_q[j] <= rem_d[j];
        nlo_q[j] <= nlo_q[j-1];
        quo_q[j] <= quo_d[j];
        den_q[j] <= den_q[j-1];
        neg_q[j] <= neg_q[j-1];
        rig_q[j] <= rig_q[j-1];
        it_q[j]  <= it_q[j-1];
      end
    end
  end

  always_comb begin
    push_ent_o.it = it_q[N];
    if (rig_q[N]) begin
      push_ent_o.refl = 32'sd1 <<< afi_pkg::R_FRAC;
    end else if (neg_q[N]) begin
      push_ent_o.refl = -$signed({1'b0, quo_q[N]});
    end else begin
      push_ent_o.refl = $signed({1'b0, quo_q[N]});
    end
  end

endmodule

[sv/afi_queue.sv]
// Short queue that decouples the coefficient front end from the flux back end.
module afi_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  afi_pkg::qent_t      push_ent_i,
  output logic                ready_o,
  input  logic                pop_i,
  output logic                empty_o,
  output afi_pkg::qent_t      head_o
);

  localparam int unsigned D = afi_pkg::QDEPTH;
  localparam int unsigned W = afi_pkg::QPTR_W;

  afi_pkg::qent_t ent_q [D];
  logic [W-1:0]   wp_q, wp_d, rp_q, rp_d;
  logic [W:0]     cnt_q, cnt_d;

  assign ready_o = cnt_q != (W+1)'(D);
  assign empty_o = cnt_q == '0;
  assign head_o  = ent_q[rp_q];

  always_comb begin
    wp_d  = push_i ? wp_q + 1'b1 : wp_q;
    rp_d  = pop_i ? rp_q + 1'b1 : rp_q;
    cnt_d = cnt_q + (W+1)'(push_i) - (W+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= push_ent_i;
    end
  end

endmodule

[sv/afi_back.sv]
// Back end: mirrored wall state, jumps and upwind flux, ending in the output register.
module afi_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  afi_pkg::qent_t      head_i,
  output logic                pop_o,
  input  logic [24:0]         inv_density_i,
  input  logic [22:0]         sound_speed_sq_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  flux_pressure_o,
  output logic signed [31:0]  flux_vel_x_o,
  output logic signed [31:0]  flux_vel_y_o
);

  localparam int unsigned NS = afi_pkg::NSTAGE_B;

  logic                 v_q   [0:NS-1];
  afi_pkg::qent_t       c_q   [0:NS-3];
  logic                 en;

  logic signed [47:0]   m1_q, m2_q, m4_q, m5_q;
  logic signed [63:0]   mp_q, m3_q, mx_q, my_q;
  logic signed [31:0]   unm_q, unm_d;
  logic signed [32:0]   pw2_q, pw3_q, pw4_q, pw5_q, pw2_d;
  logic signed [32:0]   unp_q, unp_d;
  logic signed [31:0]   utx_q, uty_q, utx5_q, uty5_q, utx_d, uty_d;
  logic signed [48:0]   m6_q, m7_q, m8_q, m9_q;
  logic signed [33:0]   dp_q, dp_d;
  logic signed [32:0]   dx_q, dy_q, dx_d, dy_d;
  logic signed [59:0]   ma_q;
  logic signed [35:0]   dun_q, dun_d;
  logic signed [43:0]   a8_q, a9_q, a_d;
  logic signed [59:0]   bb_q;
  logic signed [31:0]   fp10_q, fp11_q, fp_d, fx_q, fy_q, fx_d, fy_d, fp_out_q;
  logic signed [48:0]   fun_q, fun_d;

  assign en              = !v_q[NS-1] || out_ready_i;
  assign pop_o           = en && !empty_i;
  assign out_valid_o     = v_q[NS-1];
  assign flux_pressure_o = fp_out_q;
  assign flux_vel_x_o    = fx_q;
  assign flux_vel_y_o    = fy_q;

  always_comb begin
    afi_pkg::wide_t t1, t2, uxw, uyw;
    logic signed [32:0] pp;
    logic signed [31:0] uxp, uyp;
    unm_d = afi_pkg::sat32(afi_pkg::rnd_shr(afi_pkg::wide_t'(m1_q) + afi_pkg::wide_t'(m2_q),
                                            afi_pkg::NORM_FRAC));
    t1    = afi_pkg::rnd_shr(afi_pkg::wide_t'(mp_q), afi_pkg::R_FRAC);
    pw2_d = t1[32:0];
    t2    = -afi_pkg::rnd_shr(afi_pkg::wide_t'(m3_q), afi_pkg::R_FRAC);
    unp_d = t2[32:0];
    utx_d = afi_pkg::sat32(afi_pkg::wide_t'(c_q[3].it.ux_in)
                           - afi_pkg::rnd_shr(afi_pkg::wide_t'(m4_q), afi_pkg::NORM_FRAC));
    uty_d = afi_pkg::sat32(afi_pkg::wide_t'(c_q[3].it.uy_in)
                           - afi_pkg::rnd_shr(afi_pkg::wide_t'(m5_q), afi_pkg::NORM_FRAC));
    uxw   = afi_pkg::rnd_shr(afi_pkg::wide_t'(m6_q), afi_pkg::NORM_FRAC)
            + afi_pkg::wide_t'(utx5_q);
    uyw   = afi_pkg::rnd_shr(afi_pkg::wide_t'(m7_q), afi_pkg::NORM_FRAC)
            + afi_pkg::wide_t'(uty5_q);
    // Wall nodes use the mirrored neighbour state.
    if (c_q[5].it.wall) begin
      pp  = pw5_q;
      uxp = afi_pkg::sat32(uxw);
      uyp = afi_pkg::sat32(uyw);
    end else begin
      pp  = 33'(c_q[5].it.p_out);
      uxp = c_q[5].it.ux_out;
      uyp = c_q[5].it.uy_out;
    end
    dp_d  = 34'(pp) - 34'(c_q[5].it.p_in);
    dx_d  = 33'(uxp) - 33'(c_q[5].it.ux_in);
    dy_d  = 33'(uyp) - 33'(c_q[5].it.uy_in);
    t1    = afi_pkg::rnd_shr(afi_pkg::wide_t'(m8_q) + afi_pkg::wide_t'(m9_q),
                             afi_pkg::NORM_FRAC);
    dun_d = t1[35:0];
    t2    = afi_pkg::rnd_shr(afi_pkg::wide_t'(ma_q), afi_pkg::FRAC_BITS);
    a_d   = t2[43:0];
    fp_d  = afi_pkg::sat32(afi_pkg::rnd_shr(afi_pkg::wide_t'(a9_q) - afi_pkg::wide_t'(bb_q), 1));
    fun_d = afi_pkg::clamp48(afi_pkg::rnd_shr(afi_pkg::wide_t'(bb_q) - afi_pkg::wide_t'(a9_q), 1));
    fx_d  = afi_pkg::sat32(afi_pkg::rnd_shr(afi_pkg::wide_t'(mx_q), afi_pkg::NORM_FRAC));
    fy_d  = afi_pkg::sat32(afi_pkg::rnd_shr(afi_pkg::wide_t'(my_q), afi_pkg::NORM_FRAC));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NS; k++) begin
        v_q[k] <= 1'b0;
      end
    end else if (en) begin
      v_q[0] <= !empty_i;
      for (int k = 1; k < NS; k++) begin
        v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q[0] <= head_i;
      for (int k = 1; k < NS - 2; k++) begin
        c_q[k] <= c_q[k-1];
      end
      m1_q     <= 48'(c_q[0].it.ux_in) * 48'(c_q[0].it.nx);
      m2_q     <= 48'(c_q[0].it.uy_in) * 48'(c_q[0].it.ny);
      mp_q     <= 64'(c_q[0].refl) * 64'(c_q[0].it.p_in);
      unm_q    <= unm_d;
      pw2_q    <= pw2_d;
      m3_q     <= 64'(c_q[2].refl) * 64'(unm_q);
      m4_q     <= 48'(unm_q) * 48'(c_q[2].it.nx);
      m5_q     <= 48'(unm_q) * 48'(c_q[2].it.ny);
      pw3_q    <= pw2_q;
      unp_q    <= unp_d;
      utx_q    <= utx_d;
      uty_q    <= uty_d;
      pw4_q    <= pw3_q;
      m6_q     <= 49'(unp_q) * 49'(c_q[4].it.nx);
      m7_q     <= 49'(unp_q) * 49'(c_q[4].it.ny);
      utx5_q   <= utx_q;
      uty5_q   <= uty_q;
      pw5_q    <= pw4_q;
      dp_q     <= dp_d;
      dx_q     <= dx_d;
      dy_q     <= dy_d;
      m8_q     <= 49'(dx_q) * 49'(c_q[6].it.nx);
      m9_q     <= 49'(dy_q) * 49'(c_q[6].it.ny);
      ma_q     <= 60'($signed({1'b0, inv_density_i})) * 60'(dp_q);
      dun_q    <= dun_d;
      a8_q     <= a_d;
      bb_q     <= 60'($signed({1'b0, sound_speed_sq_i})) * 60'(dun_q);
      a9_q     <= a8_q;
      fp10_q   <= fp_d;
      fun_q    <= fun_d;
      mx_q     <= 64'(fun_q) * 64'(c_q[10].it.nx);
      my_q     <= 64'(fun_q) * 64'(c_q[10].it.ny);
      fp11_q   <= fp10_q;
      fx_q     <= fx_d;
      fy_q     <= fy_d;
      fp_out_q <= fp11_q;
    end
  end

endmodule

[sv/acoustic_face_flux_impedance_top.sv]
// Top level of the upwind acoustic face flux block.
//
// Input words arrive on s_axis: tdata carries the interior and neighbour
// pressure and velocity, the outward normal and the wall impedance, and
// tuser carries the boundary flag. Each word yields exactly one result word
// on m_axis with the pressure flux and both velocity fluxes, in order.
// The block takes one word every cycle when the output is not stalled.
// Each word passes through the front end, where the one-bit-per-stage
// pipelined divider forms the reflection coefficient, then through the
// four-entry queue and last through the flux back end's multiply stages.
// When m_axis_tready is low the result holds in the output register and the
// back end stops; the front end keeps accepting until the queue fills and
// then drops s_axis_tready. Reset clears all pipeline valid flags and the
// queue and loads the registers with their default values. Configuration
// writes are applied at once, so they should be made only while the block
// is idle.
module acoustic_face_flux_impedance_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // p_in, ux_in, uy_in, p_out, ux_out, uy_out, nx, ny, wall_impedance
  input  logic [255:0]  s_axis_tdata,
  // on_wall
  input  logic [0:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // flux_pressure, flux_vel_x, flux_vel_y
  output logic [95:0]   m_axis_tdata,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [31:0]   cfg_data_i
);

  logic [24:0]         inv_density_q;
  logic [22:0]         sound_speed_sq_q;
  logic [31:0]         char_impedance_q;

  afi_pkg::item_t      in_item;
  afi_pkg::qent_t      push_ent, head;
  logic                push, push_ready, pop, empty;
  logic signed [31:0]  flux_pressure, flux_vel_x, flux_vel_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_density_q    <= 25'd54613;
      sound_speed_sq_q <= 23'd117649;
      char_impedance_q <= 32'd105728;
    end else if (cfg_we_i) begin
      case (afi_pkg::cfg_idx_e'(cfg_idx_i))
        afi_pkg::CFG_INV_DENSITY:    inv_density_q    <= cfg_data_i[24:0];
        afi_pkg::CFG_SOUND_SPEED_SQ: sound_speed_sq_q <= cfg_data_i[22:0];
        afi_pkg::CFG_CHAR_IMPEDANCE: char_impedance_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    in_item.p_in   = s_axis_tdata[31:0];
    in_item.ux_in  = s_axis_tdata[63:32];
    in_item.uy_in  = s_axis_tdata[95:64];
    in_item.p_out  = s_axis_tdata[127:96];
    in_item.ux_out = s_axis_tdata[159:128];
    in_item.uy_out = s_axis_tdata[191:160];
    in_item.nx     = s_axis_tdata[207:192];
    in_item.ny     = s_axis_tdata[223:208];
    in_item.zw     = s_axis_tdata[255:224];
    in_item.wall   = s_axis_tuser[0];
  end

  afi_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .in_item_i        (in_item),
    .char_impedance_i (char_impedance_q),
    .push_o           (push),
    .push_ready_i     (push_ready),
    .push_ent_o       (push_ent)
  );

  afi_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_ent_i (push_ent),
    .ready_o    (push_ready),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head)
  );

  afi_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .empty_i          (empty),
    .head_i           (head),
    .pop_o            (pop),
    .inv_density_i    (inv_density_q),
    .sound_speed_sq_i (sound_speed_sq_q),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .flux_pressure_o  (flux_pressure),
    .flux_vel_x_o     (flux_vel_x),
    .flux_vel_y_o     (flux_vel_y)
  );

  assign m_axis_tdata = {flux_vel_y, flux_vel_x, flux_pressure};

endmodule

[sim/acoustic_face_flux_impedance_top_test.sv]
// Self-checking testbench for the acoustic face flux block with a scoreboard class.
`timescale 1ns / 100ps

module acoustic_face_flux_impedance_top_test;

  // Packed to match m_axis_tdata, flux_pressure in the lowest bits.
  typedef struct packed {
    logic signed [31:0] fy;
    logic signed [31:0] fx;
    logic signed [31:0] fp;
  } flux_t;

  // Rounding right shift, ties away from zero.
  function automatic longint rshift_rnd(longint x, int s);
    longint m;
    m = (x < 0) ? -x : x;
    m = (m + (longint'(1) << (s - 1))) >>> s;
    return (x < 0) ? -m : m;
  endfunction

  function automatic longint clip(longint x, longint lo, longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  function automatic longint clip32(longint x);
    return clip(x, -64'sd2147483648, 64'sd2147483647);
  endfunction

  class flux_board;
    longint unsigned inv_rho, c_sq, z_char;
    flux_t pending_q[$];
    int errors;

    function new();
      inv_rho = 54613;
      c_sq = 117649;
      z_char = 105728;
      errors = 0;
    endfunction

    function longint refl_coef(longint unsigned zw);
      longint num;
      longint unsigned den, m;
      if (zw == 0) return longint'(1) << afi_pkg::R_FRAC;
      num = longint'(zw) - longint'(z_char);
      den = zw + z_char;
      m = (num < 0) ? -num : num;
      m = ((m << afi_pkg::R_FRAC) + den / 2) / den;
      return (num < 0) ? -longint'(m) : longint'(m);
    endfunction

    function void note_item(afi_pkg::item_t it);
      longint pm, uxm, uym, pp, uxp, uyp, nx, ny, r, unm, unp, utx, uty;
      longint dp, dun, a, b, fun;
      flux_t f;
      pm = it.p_in; uxm = it.ux_in; uym = it.uy_in;
      pp = it.p_out; uxp = it.ux_out; uyp = it.uy_out;
      nx = it.nx; ny = it.ny;
      if (it.wall) begin
        r = refl_coef(it.zw);
        unm = clip32(rshift_rnd(uxm * nx + uym * ny, afi_pkg::NORM_FRAC));
        unp = -rshift_rnd(r * unm, afi_pkg::R_FRAC);
        utx = clip32(uxm - rshift_rnd(unm * nx, afi_pkg::NORM_FRAC));
        uty = clip32(uym - rshift_rnd(unm * ny, afi_pkg::NORM_FRAC));
        pp = rshift_rnd(r * pm, afi_pkg::R_FRAC);
        uxp = clip32(rshift_rnd(unp * nx, afi_pkg::NORM_FRAC) + utx);
        uyp = clip32(rshift_rnd(unp * ny, afi_pkg::NORM_FRAC) + uty);
      end
      dp = pp - pm;
      dun = rshift_rnd((uxp - uxm) * nx + (uyp - uym) * ny, afi_pkg::NORM_FRAC);
      a = rshift_rnd(longint'(inv_rho) * dp, afi_pkg::FRAC_BITS);
      b = longint'(c_sq) * dun;
      fun = clip(rshift_rnd(b - a, 1), -(longint'(1) << 47), longint'(1) << 47);
      f.fp = clip32(rshift_rnd(a - b, 1));
      f.fx = clip32(rshift_rnd(fun * nx, afi_pkg::NORM_FRAC));
      f.fy = clip32(rshift_rnd(fun * ny, afi_pkg::NORM_FRAC));
      pending_q.push_back(f);
    endfunction

    function void check_flux(flux_t got);
      flux_t w;
      if (pending_q.size() == 0) begin
        $error("unexpected result word %h", got);
        errors++;
        return;
      end
      w = pending_q.pop_front();
      if (got.fp !== w.fp) begin
        $error("flux_pressure expected %0d actual %0d", w.fp, got.fp); errors++;
      end
      if (got.fx !== w.fx) begin
        $error("flux_vel_x expected %0d actual %0d", w.fx, got.fx); errors++;
      end
      if (got.fy !== w.fy) begin
        $error("flux_vel_y expected %0d actual %0d", w.fy, got.fy); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [255:0] s_axis_tdata = '0;
  logic [0:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = afi_pkg::CFG_INV_DENSITY;
  logic [31:0] cfg_data_i = '0;

  flux_board board = new();
  int stall_mode = 0;

  acoustic_face_flux_impedance_top i_dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Pack an item: tdata holds every field but on_wall, first field lowest.
  function automatic logic [255:0] pack_item(afi_pkg::item_t it);
    return {it.zw, it.ny, it.nx, it.uy_out, it.ux_out, it.p_out,
            it.uy_in, it.ux_in, it.p_in};
  endfunction

  task automatic send_item(afi_pkg::item_t it);
    s_axis_tdata  <= pack_item(it);
    s_axis_tuser  <= it.wall;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_item(it);
  endtask

  task automatic idle_gap(int n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    idle_gap(0);
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(afi_pkg::cfg_idx_e idx, logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      afi_pkg::CFG_INV_DENSITY:    board.inv_rho = val & 32'h1FF_FFFF;
      afi_pkg::CFG_SOUND_SPEED_SQ: board.c_sq    = val & 32'h7F_FFFF;
      default:                     board.z_char  = val;
    endcase
  endtask

  function automatic logic signed [31:0] rnd32(int k);
    case (k % 6)
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $signed($urandom);
      default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
    endcase
  endfunction

  function automatic afi_pkg::item_t rand_item();
    afi_pkg::item_t it;
    int ang;
    it.p_in = rnd32($urandom); it.ux_in = rnd32($urandom); it.uy_in = rnd32($urandom);
    it.p_out = rnd32($urandom); it.ux_out = rnd32($urandom); it.uy_out = rnd32($urandom);
    ang = $urandom_range(0, 3);
    if (ang == 0) begin
      it.nx = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
      it.ny = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
    end else if (ang == 1) begin
      it.nx = ($urandom & 1) ? 16'sd16384 : -16'sd16384; it.ny = 0;
    end else begin
      it.nx = ($urandom & 1) ? 16'sd11585 : -16'sd11585;
      it.ny = ($urandom & 1) ? 16'sd11585 : -16'sd11585;
    end
    it.wall = $urandom & 1;
    case ($urandom_range(0, 3))
      0: it.zw = 0;
      1: it.zw = $urandom;
      default: it.zw = $urandom_range(1, 400000);
    endcase
    return it;
  endfunction

  task automatic directed_set();
    afi_pkg::item_t it;
    for (int k = 0; k < 20; k++) begin
      it = rand_item();
      it.p_in = rnd32(k); it.ux_in = rnd32(k + 1); it.uy_in = rnd32(k + 3);
      it.p_out = rnd32(k + 4); it.ux_out = rnd32(k + 1); it.uy_out = rnd32(k);
      it.nx = (k % 4 == 0) ? 16'sd16384 : ((k % 4 == 1) ? -16'sd16384 : 16'sd3);
      it.ny = (k % 4 == 2) ? -16'sd16384 : 16'sd16384;
      it.wall = k[0];
      it.zw = (k % 3 == 0) ? 32'd0 : ((k % 3 == 1) ? 32'hFFFF_FFFF : 32'd105728);
      send_item(it);
    end
  endtask

  task automatic random_burst(int count);
    int left;
    left = count;
    while (left > 0) begin
      for (int b = $urandom_range(1, 30); b > 0 && left > 0; b--) begin
        send_item(rand_item());
        left--;
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 8));
    end
  endtask

  // Receiver stalls in changing patterns, including long stretches of no stall.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) board.check_flux(m_axis_tdata);
    if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready <= $urandom & 1;
      default: m_axis_tready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_set();
    drain();
    // Zero impedance register, minimum inverse density and squared speed.
    write_reg(afi_pkg::CFG_CHAR_IMPEDANCE, 32'd0);
    write_reg(afi_pkg::CFG_INV_DENSITY, 32'd1);
    write_reg(afi_pkg::CFG_SOUND_SPEED_SQ, 32'd1);
    directed_set();
    random_burst(150);
    drain();
    write_reg(afi_pkg::CFG_CHAR_IMPEDANCE, 32'hFFFF_FFFF);
    write_reg(afi_pkg::CFG_INV_DENSITY, 32'd16777216);
    write_reg(afi_pkg::CFG_SOUND_SPEED_SQ, 32'd4194304);
    random_burst(250);
    drain();
    for (int ph = 0; ph < 2; ph++) begin
      write_reg(afi_pkg::CFG_CHAR_IMPEDANCE, $urandom_range(1, 400000));
      write_reg(afi_pkg::CFG_INV_DENSITY, $urandom_range(1, 16777216));
      write_reg(afi_pkg::CFG_SOUND_SPEED_SQ, $urandom_range(1, 4194304));
      random_burst(220);
      drain();
    end
    if (board.errors == 0) begin
      $display("[acoustic_face_flux_impedance_top] OK");
    end else begin
      $display("[acoustic_face_flux_impedance_top] ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("[acoustic_face_flux_impedance_top] ERROR");
    $finish;
  end

endmodule

[sim.f]
sv/afi_pkg.sv
sv/afi_front.sv
sv/afi_queue.sv
sv/afi_back.sv
sv/acoustic_face_flux_impedance_top.sv
sim/acoustic_face_flux_impedance_top_test.sv
